/* sv/tccw_pkg.sv */
// Shared types, codes and microcode program of the text console cursor writer.
package tccw_pkg;

    // Field widths fixed by the console interface.
    localparam int ByteW   = 8;
    localparam int WordW   = 16;
    localparam int HexW    = 32;
    localparam int CountW  = 4;
    localparam int StepW   = 4;
    localparam int CfgIdxW = 2;

    // Default digit limit and the number of nibbles in the hex value.
    localparam int MaxHexDigitsDefault = 8;
    localparam int HexNibbles          = HexW / 4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgColumns   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgRows      = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgAttribute = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [ByteW-1:0] ColumnsReset   = 8'd80;
    localparam logic [ByteW-1:0] RowsReset      = 8'd25;
    localparam logic [ByteW-1:0] AttributeReset = 8'd7;

    // Character codes.
    localparam logic [ByteW-1:0] CharCr = 8'd13;
    localparam logic [ByteW-1:0] CharLf = 8'd10;

    // Display controller register indexes.
    localparam logic [3:0] RegStartHi  = 4'hc;
    localparam logic [3:0] RegStartLo  = 4'hd;
    localparam logic [3:0] RegCursorHi = 4'he;
    localparam logic [3:0] RegCursorLo = 4'hf;

    // Result kinds.
    localparam logic KindCell = 1'b0;
    localparam logic KindReg  = 1'b1;

    // Location source.
    localparam logic LocSum = 1'b0;
    localparam logic LocReg = 1'b1;

    // Column operand of the address adder.
    localparam logic AddCol = 1'b0;
    localparam logic AddPos = 1'b1;

    // Value source.
    localparam logic [2:0] ValChar   = 3'd0;
    localparam logic [2:0] ValHex    = 3'd1;
    localparam logic [2:0] ValSumHi  = 3'd2;
    localparam logic [2:0] ValSumLo  = 3'd3;
    localparam logic [2:0] ValProdHi = 3'd4;
    localparam logic [2:0] ValProdLo = 3'd5;

    // Multiplier operation.
    localparam logic [1:0] MulNone   = 2'd0;
    localparam logic [1:0] MulRow    = 2'd1;
    localparam logic [1:0] MulScroll = 2'd2;

    // Datapath operation.
    localparam logic [2:0] OpNone     = 3'd0;
    localparam logic [2:0] OpCharAdv  = 3'd1;
    localparam logic [2:0] OpCol0     = 3'd2;
    localparam logic [2:0] OpNewline  = 3'd3;
    localparam logic [2:0] OpHexSetup = 3'd4;
    localparam logic [2:0] OpHexStep  = 3'd5;

    // Last flag mode.
    localparam logic [1:0] LastNone   = 2'd0;
    localparam logic [1:0] LastAlways = 2'd1;
    localparam logic [1:0] LastNoScr  = 2'd2;

    // Jump conditions.
    localparam logic [3:0] JNext   = 4'd0;
    localparam logic [3:0] JAlways = 4'd1;
    localparam logic [3:0] JWait   = 4'd2;
    localparam logic [3:0] JHex    = 4'd3;
    localparam logic [3:0] JCr     = 4'd4;
    localparam logic [3:0] JLf     = 4'd5;
    localparam logic [3:0] JNoDig  = 4'd6;
    localparam logic [3:0] JMore   = 4'd7;
    localparam logic [3:0] JNoScr  = 4'd8;

    // Program steps.
    localparam logic [StepW-1:0] StepIdle     = 4'd0;
    localparam logic [StepW-1:0] StepMulRow   = 4'd1;
    localparam logic [StepW-1:0] StepChkCr    = 4'd2;
    localparam logic [StepW-1:0] StepChkLf    = 4'd3;
    localparam logic [StepW-1:0] StepCell     = 4'd4;
    localparam logic [StepW-1:0] StepCr       = 4'd5;
    localparam logic [StepW-1:0] StepLf       = 4'd6;
    localparam logic [StepW-1:0] StepHexSetup = 4'd7;
    localparam logic [StepW-1:0] StepHexDigit = 4'd8;
    localparam logic [StepW-1:0] StepCurMul   = 4'd9;
    localparam logic [StepW-1:0] StepCurHi    = 4'd10;
    localparam logic [StepW-1:0] StepCurLo    = 4'd11;
    localparam logic [StepW-1:0] StepScrMul   = 4'd12;
    localparam logic [StepW-1:0] StepScrHi    = 4'd13;
    localparam logic [StepW-1:0] StepScrLo    = 4'd14;
    localparam logic [StepW-1:0] StepUnused   = 4'd15;

    // One request on the command channel.
    typedef struct packed {
        logic               cmd;
        logic [ByteW-1:0]   char_code;
        logic [HexW-1:0]    hex_value;
        logic [CountW-1:0]  digit_count;
    } cmd_item_t;

    // One result on the output channel.
    typedef struct packed {
        logic               kind;
        logic [WordW-1:0]   location;
        logic [WordW-1:0]   value;
        logic               last;
    } res_item_t;

    // One microcode control word.
    typedef struct packed {
        logic              emit;
        logic [1:0]        last_mode;
        logic              kind;
        logic [3:0]        reg_loc;
        logic              loc_sel;
        logic              add_sel;
        logic [2:0]        val_sel;
        logic [1:0]        mul_sel;
        logic [2:0]        dp_op;
        logic [3:0]        jcond;
        logic [StepW-1:0]  target;
    } ctl_word_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        ctl_word_t word;
        logic      advance;
        logic      load;
    } seq_ctl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic is_hex;
        logic is_cr;
        logic is_lf;
        logic no_digits;
        logic more_digits;
        logic no_scroll;
        logic out_free;
    } dp_stat_t;

    // Builds a control word from its fields.
    function automatic ctl_word_t mk_word(
        input logic             emit,
        input logic [1:0]       last_mode,
        input logic             kind,
        input logic [3:0]       reg_loc,
        input logic             loc_sel,
        input logic             add_sel,
        input logic [2:0]       val_sel,
        input logic [1:0]       mul_sel,
        input logic [2:0]       dp_op,
        input logic [3:0]       jcond,
        input logic [StepW-1:0] target
    );
        ctl_word_t w;
        w.emit      = emit;
        w.last_mode = last_mode;
        w.kind      = kind;
        w.reg_loc   = reg_loc;
        w.loc_sel   = loc_sel;
        w.add_sel   = add_sel;
        w.val_sel   = val_sel;
        w.mul_sel   = mul_sel;
        w.dp_op     = dp_op;
        w.jcond     = jcond;
        w.target    = target;
        return w;
    endfunction

    // The microcode program, one control word per step.
    function automatic ctl_word_t ucode_rom(input logic [StepW-1:0] step);
        ctl_word_t w;
        case (step)
            StepIdle:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulNone, OpNone, JWait, StepIdle);
            StepMulRow:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulRow, OpNone, JHex, StepHexSetup);
            StepChkCr:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulNone, OpNone, JCr, StepCr);
            StepChkLf:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulNone, OpNone, JLf, StepLf);
            StepCell:
                w = mk_word(1'b1, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulNone, OpCharAdv, JAlways, StepCurMul);
            StepCr:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulNone, OpCol0, JAlways, StepCurMul);
            StepLf:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulNone, OpNewline, JAlways, StepCurMul);
            StepHexSetup:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulNone, OpHexSetup, JNoDig, StepCurMul);
            StepHexDigit:
                w = mk_word(1'b1, LastNone, KindCell, 4'h0, LocSum, AddPos, ValHex,
                            MulNone, OpHexStep, JMore, StepHexDigit);
            StepCurMul:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulRow, OpNone, JNext, StepIdle);
            StepCurHi:
                w = mk_word(1'b1, LastNone, KindReg, RegCursorHi, LocReg, AddCol, ValSumHi,
                            MulNone, OpNone, JNext, StepIdle);
            StepCurLo:
                w = mk_word(1'b1, LastNoScr, KindReg, RegCursorLo, LocReg, AddCol, ValSumLo,
                            MulNone, OpNone, JNoScr, StepIdle);
            StepScrMul:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulScroll, OpNone, JNext, StepIdle);
            StepScrHi:
                w = mk_word(1'b1, LastNone, KindReg, RegStartHi, LocReg, AddCol, ValProdHi,
                            MulNone, OpNone, JNext, StepIdle);
            StepScrLo:
                w = mk_word(1'b1, LastAlways, KindReg, RegStartLo, LocReg, AddCol, ValProdLo,
                            MulNone, OpNone, JAlways, StepIdle);
            default:
                w = mk_word(1'b0, LastNone, KindCell, 4'h0, LocSum, AddCol, ValChar,
                            MulNone, OpNone, JAlways, StepIdle);
        endcase
        return w;
    endfunction

    // Uppercase hexadecimal character of one nibble.
    function automatic logic [ByteW-1:0] hex_char(input logic [3:0] d);
        logic [ByteW-1:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else begin
            c = 8'h41 + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

/* sv/tccw_sequencer.sv */
// Microcode sequencer: step counter, program table and jump selection.
module tccw_sequencer
    import tccw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  dp_stat_t stat,
    output seq_ctl_t seq
);

    logic [StepW-1:0] pc_reg;
    logic [StepW-1:0] pc_next;
    ctl_word_t        word;
    logic             advance;
    logic             taken;

    // Fetch the control word of the current step.
    assign word = ucode_rom(pc_reg);

    // An emitting step waits until the output register is free.
    assign advance = !word.emit || stat.out_free;

    // Requests are taken only at the idle step.
    assign cmd_stall = (pc_reg != StepIdle);

    // Jump condition selection.
    always_comb
    begin
        case (word.jcond)
            JNext:   taken = 1'b0;
            JAlways: taken = 1'b1;
            JWait:   taken = !cmd_valid;
            JHex:    taken = stat.is_hex;
            JCr:     taken = stat.is_cr;
            JLf:     taken = stat.is_lf;
            JNoDig:  taken = stat.no_digits;
            JMore:   taken = stat.more_digits;
            JNoScr:  taken = stat.no_scroll;
            default: taken = 1'b1;
        endcase
    end

    // Next step.
    always_comb
    begin
        pc_next = pc_reg;
        if (advance) begin
            pc_next = taken ? word.target : pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg <= StepIdle;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign seq.word    = word;
    assign seq.advance = advance;
    assign seq.load    = cmd_valid && (pc_reg == StepIdle);

    // The program never reaches the spare step.
    a_no_spare_step: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg != StepUnused)
        else $error("sequencer reached the spare step");

    // A blocked emitting step holds its place.
    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (word.emit && !stat.out_free) |=> (pc_reg == $past(pc_reg)))
        else $error("emitting step moved while the output was full");

endmodule

/* sv/tccw_datapath.sv */
// Datapath: configuration, cursor, digit registers, multiplier and output register.
module tccw_datapath
    import tccw_pkg::*;
#(
    parameter int MAX_HEX_DIGITS = MaxHexDigitsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [ByteW-1:0]   cfg_data,
    input  cmd_item_t          cmd_data,
    input  seq_ctl_t           seq,
    output dp_stat_t           stat,
    output logic               res_valid,
    input  logic               res_stall,
    output res_item_t          res_data
);

    localparam int HexLimit = (MAX_HEX_DIGITS < HexNibbles) ? MAX_HEX_DIGITS : HexNibbles;

    logic [ByteW-1:0]  columns_reg;
    logic [ByteW-1:0]  rows_reg;
    logic [ByteW-1:0]  attribute_reg;
    logic [ByteW-1:0]  col_reg, col_next;
    logic [ByteW-1:0]  row_reg, row_next;
    logic              cmd_reg;
    logic [ByteW-1:0]  char_reg;
    logic [HexW-1:0]   val_reg, val_next;
    logic [ByteW-1:0]  pos_reg, pos_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic [WordW-1:0]  prod_reg;
    logic              res_valid_reg;
    res_item_t         res_data_reg;

    logic [ByteW-1:0]  cols_eff;
    logic [ByteW-1:0]  rows_eff;
    logic              scroll;
    logic [ByteW-1:0]  scroll_rows;
    logic [ByteW-1:0]  mul_a;
    logic [WordW-1:0]  sum;
    logic [ByteW-1:0]  add_b;
    logic [ByteW:0]    hex_end;
    logic [CountW-1:0] n_sat;
    logic              fire;
    res_item_t         res_new;

    // A zero geometry value counts as one.
    assign cols_eff    = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
    assign rows_eff    = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
    assign scroll      = (row_reg >= rows_eff);
    assign scroll_rows = row_reg - rows_eff + 8'd1;

    // Digit count saturates at the digit limit.
    assign n_sat = (cmd_data.digit_count > CountW'(HexLimit)) ? CountW'(HexLimit)
                                                              : cmd_data.digit_count;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            columns_reg   <= ColumnsReset;
            rows_reg      <= RowsReset;
            attribute_reg <= AttributeReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CfgColumns:   columns_reg   <= cfg_data;
                CfgRows:      rows_reg      <= cfg_data;
                CfgAttribute: attribute_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Request fields are captured when the sequencer takes a request.
    always_ff @(posedge clk)
    begin
        if (seq.load) begin
            cmd_reg  <= cmd_data.cmd;
            char_reg <= cmd_data.char_code;
        end
    end

    // Multiplier: row or scroll row count times the column count.
    assign mul_a = (seq.word.mul_sel == MulScroll) ? scroll_rows : row_reg;

    always_ff @(posedge clk)
    begin
        if (seq.word.mul_sel != MulNone) begin
            prod_reg <= {8'd0, mul_a} * {8'd0, cols_eff};
        end
    end

    // Cursor and digit register updates, applied when the step advances.
    assign hex_end = {1'b0, col_reg} + {5'd0, cnt_reg};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        val_next = val_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        if (seq.load) begin
            val_next = cmd_data.hex_value;
            cnt_next = n_sat;
        end else if (seq.advance) begin
            case (seq.word.dp_op)
                OpCharAdv:
                begin
                    if (col_reg < cols_eff - 8'd1) begin
                        col_next = col_reg + 8'd1;
                    end else begin
                        col_next = 8'd0;
                        row_next = row_reg + 8'd1;
                    end
                end
                OpCol0:
                begin
                    col_next = 8'd0;
                end
                OpNewline:
                begin
                    col_next = 8'd0;
                    row_next = row_reg + 8'd1;
                end
                OpHexSetup:
                begin
                    col_next = hex_end[ByteW-1:0];
                    pos_next = hex_end[ByteW-1:0] - 8'd1;
                end
                OpHexStep:
                begin
                    val_next = {4'd0, val_reg[HexW-1:4]};
                    pos_next = pos_reg - 8'd1;
                    cnt_next = cnt_reg - 4'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg <= 8'd0;
            row_reg <= 8'd0;
            cnt_reg <= 4'd0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        pos_reg <= pos_next;
    end

    // Address adder and result assembly.
    assign add_b = (seq.word.add_sel == AddPos) ? pos_reg : col_reg;
    assign sum   = prod_reg + {8'd0, add_b};

    always_comb
    begin
        res_new.kind     = seq.word.kind;
        res_new.location = (seq.word.loc_sel == LocReg) ? {12'd0, seq.word.reg_loc} : sum;
        case (seq.word.val_sel)
            ValChar:   res_new.value = {attribute_reg, char_reg};
            ValHex:    res_new.value = {attribute_reg, hex_char(val_reg[3:0])};
            ValSumHi:  res_new.value = {8'd0, sum[WordW-1:ByteW]};
            ValSumLo:  res_new.value = {8'd0, sum[ByteW-1:0]};
            ValProdHi: res_new.value = {8'd0, prod_reg[WordW-1:ByteW]};
            ValProdLo: res_new.value = {8'd0, prod_reg[ByteW-1:0]};
            default:   res_new.value = {WordW{1'b0}};
        endcase
        case (seq.word.last_mode)
            LastAlways: res_new.last = 1'b1;
            LastNoScr:  res_new.last = !scroll;
            default:    res_new.last = 1'b0;
        endcase
    end

    // Output register.
    assign stat.out_free = !res_valid_reg || !res_stall;
    assign fire          = seq.word.emit && stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (fire) begin
            res_valid_reg <= 1'b1;
        end else if (!res_stall) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            res_data_reg <= res_new;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Status to the sequencer.
    assign stat.is_hex      = cmd_reg;
    assign stat.is_cr       = (char_reg == CharCr);
    assign stat.is_lf       = (char_reg == CharLf);
    assign stat.no_digits   = (cnt_reg == 4'd0);
    assign stat.more_digits = (cnt_reg != 4'd1);
    assign stat.no_scroll   = !scroll;

    // The digit counter never exceeds the digit limit.
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CountW'(HexLimit))
        else $error("hex digit counter above its limit");

endmodule

/* sv/text_console_cursor_writer_unit.sv */
// Top level of the text console cursor writer.
// Each request takes one pass through a small microcode program and produces its
// results through a registered output. A hex request gives one result per digit,
// a row below the visible screen adds the two start address writes, and output
// stalls hold the program at its emitting step. A new request is taken when the
// sequencer is back at its idle step, which can be while the final result still waits.
module text_console_cursor_writer_unit
    import tccw_pkg::*;
#(
    parameter int MAX_HEX_DIGITS = MaxHexDigitsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [ByteW-1:0]   cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cmd_item_t          cmd_data,
    output logic               res_valid,
    input  logic               res_stall,
    output res_item_t          res_data
);

    seq_ctl_t seq;
    dp_stat_t stat;

    // Program sequencer.
    tccw_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .seq       (seq)
    );

    // Datapath and output register.
    tccw_datapath #(
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_data  (cmd_data),
        .seq       (seq),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // A taken request keeps the command channel busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("request taken without the sequencer going busy");

endmodule
